[hw/rtl/mfsv_pkg.sv]
// Shared constants, control word layout and microcode table of the meter frame search.
package mfsv_pkg;

    // Default sizes
    localparam int BufferDepthDef = 256;
    localparam int MaxDataLenDef  = 200;

    // Frame format constants
    localparam logic [7:0] FrameHead   = 8'h68;
    localparam logic [7:0] FrameTail   = 8'h16;
    localparam logic [7:0] AddrWild    = 8'hAA;
    localparam logic [7:0] FrameFixed  = 8'd12;
    localparam int         CtrlDirBit  = 7;

    // Width of the checksum loop index (data length + 10 at most)
    localparam int IdxW = 9;

    // Microcode steps
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CAND,
        ST_HEAD0,
        ST_HEAD1,
        ST_CTRL,
        ST_LEN,
        ST_SUM,
        ST_CSUM,
        ST_TAIL,
        ST_ADR0,
        ST_ADR1,
        ST_ADR2,
        ST_ADR3,
        ST_ADR4,
        ST_ADR5,
        ST_NEXT,
        ST_HIT,
        ST_MISS
    } step_t;

    // Condition selected by a control word
    typedef enum logic [3:0] {
        TEST_TRUE,
        TEST_IN_LAST,
        TEST_FITS,
        TEST_HEAD,
        TEST_CTRL,
        TEST_LEN,
        TEST_MORE,
        TEST_CSUM,
        TEST_TAIL,
        TEST_ADDR,
        TEST_OUT_FREE
    } test_t;

    // Read address source: start plus constant, or start plus loop index plus one
    typedef enum logic {
        ADDR_CONST,
        ADDR_IDX
    } addr_sel_t;

    typedef struct packed {
        step_t     pass_step;
        step_t     fail_step;
        test_t     test;
        addr_sel_t addr_sel;
        logic [3:0] offset;
        logic [2:0] abyte;
        logic      in_rdy;
        logic      s_clr;
        logic      s_inc;
        logic      acc_clr;
        logic      acc_add;
        logic      dlen_ld;
        logic      commit;
        logic      hit;
    } ctrl_t;

    function automatic ctrl_t uword(input step_t pass_step, input step_t fail_step,
                                    input test_t test, input addr_sel_t addr_sel,
                                    input logic [3:0] offset, input logic [2:0] abyte);
        ctrl_t w;
        w = '0;
        w.pass_step = pass_step;
        w.fail_step = fail_step;
        w.test      = test;
        w.addr_sel  = addr_sel;
        w.offset    = offset;
        w.abyte     = abyte;
        return w;
    endfunction

    // Microcode table. Each step tests the byte read by the previous step
    // and issues the read for the next one.
    function automatic ctrl_t ucode_rom(input step_t step);
        ctrl_t w;
        w = uword(ST_IDLE, ST_IDLE, TEST_TRUE, ADDR_CONST, 4'd0, 3'd0);
        unique case (step)
            ST_IDLE: begin
                w = uword(ST_CAND, ST_IDLE, TEST_IN_LAST, ADDR_CONST, 4'd0, 3'd0);
                w.in_rdy = 1'b1;
                w.s_clr  = 1'b1;
            end
            ST_CAND:  w = uword(ST_HEAD0, ST_MISS, TEST_FITS, ADDR_CONST, 4'd0, 3'd0);
            ST_HEAD0: w = uword(ST_HEAD1, ST_NEXT, TEST_HEAD, ADDR_CONST, 4'd7, 3'd0);
            ST_HEAD1: w = uword(ST_CTRL,  ST_NEXT, TEST_HEAD, ADDR_CONST, 4'd8, 3'd0);
            ST_CTRL:  w = uword(ST_LEN,   ST_NEXT, TEST_CTRL, ADDR_CONST, 4'd9, 3'd0);
            ST_LEN: begin
                w = uword(ST_SUM, ST_NEXT, TEST_LEN, ADDR_CONST, 4'd0, 3'd0);
                w.acc_clr = 1'b1;
                w.dlen_ld = 1'b1;
            end
            ST_SUM: begin
                w = uword(ST_SUM, ST_CSUM, TEST_MORE, ADDR_IDX, 4'd0, 3'd0);
                w.acc_add = 1'b1;
            end
            ST_CSUM:  w = uword(ST_TAIL, ST_NEXT, TEST_CSUM, ADDR_IDX, 4'd0, 3'd0);
            ST_TAIL:  w = uword(ST_ADR0, ST_NEXT, TEST_TAIL, ADDR_CONST, 4'd1, 3'd0);
            ST_ADR0:  w = uword(ST_ADR1, ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd2, 3'd0);
            ST_ADR1:  w = uword(ST_ADR2, ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd3, 3'd1);
            ST_ADR2:  w = uword(ST_ADR3, ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd4, 3'd2);
            ST_ADR3:  w = uword(ST_ADR4, ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd5, 3'd3);
            ST_ADR4:  w = uword(ST_ADR5, ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd6, 3'd4);
            ST_ADR5:  w = uword(ST_HIT,  ST_NEXT, TEST_ADDR, ADDR_CONST, 4'd0, 3'd5);
            ST_NEXT: begin
                w = uword(ST_CAND, ST_CAND, TEST_TRUE, ADDR_CONST, 4'd0, 3'd0);
                w.s_inc = 1'b1;
            end
            ST_HIT: begin
                w = uword(ST_IDLE, ST_HIT, TEST_OUT_FREE, ADDR_CONST, 4'd0, 3'd0);
                w.commit = 1'b1;
                w.hit    = 1'b1;
            end
            ST_MISS: begin
                w = uword(ST_IDLE, ST_MISS, TEST_OUT_FREE, ADDR_CONST, 4'd0, 3'd0);
                w.commit = 1'b1;
            end
            default: w = uword(ST_IDLE, ST_IDLE, TEST_TRUE, ADDR_CONST, 4'd0, 3'd0);
        endcase
        return w;
    endfunction

endpackage

[hw/rtl/mfsv_store.sv]
// Byte buffer: one write port, one read port with registered read data.
module mfsv_store #(
    parameter int BUFFER_DEPTH = mfsv_pkg::BufferDepthDef
) (
    input  logic                            aclk,
    input  logic                            wr_en,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
    input  logic [7:0]                      wr_data,
    input  logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
    output logic [7:0]                      rd_data
);

    logic [7:0] mem [BUFFER_DEPTH];
    logic [7:0] rd_data_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/mfsv_sequencer.sv]
// Step counter and microcode lookup; branches on the datapath condition.
module mfsv_sequencer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cond,
    output mfsv_pkg::ctrl_t ctrl
);

    mfsv_pkg::step_t step_reg;
    mfsv_pkg::step_t step_next;

    // Current control word
    always_comb begin
        ctrl = mfsv_pkg::ucode_rom(step_reg);
    end

    // Two-way branch per step
    always_comb begin
        step_next = cond ? ctrl.pass_step : ctrl.fail_step;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= mfsv_pkg::ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

endmodule

[hw/rtl/mfsv_datapath.sv]
// Datapath: fill count, scan start, checksum accumulator, tests and result register.
module mfsv_datapath #(
    parameter int BUFFER_DEPTH = mfsv_pkg::BufferDepthDef,
    parameter int MAX_DATA_LEN = mfsv_pkg::MaxDataLenDef
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  mfsv_pkg::ctrl_t                 ctrl,
    output logic                            cond,
    // input channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_data_byte,
    input  logic                            s_last_byte,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_found,
    output logic [7:0]                      m_frame_start,
    output logic [7:0]                      m_frame_length,
    // configuration
    input  logic                            cfg_wr_en,
    input  logic [47:0]                     cfg_wr_data,
    // buffer ports
    output logic                            wr_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] wr_addr,
    output logic [$clog2(BUFFER_DEPTH)-1:0] rd_addr,
    input  logic [7:0]                      rd_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);
    localparam int XW = CW + 10;
    localparam int IW = mfsv_pkg::IdxW;

    logic [47:0]   slave_address_reg;
    logic [CW-1:0] fill_reg;
    logic [CW-1:0] s_reg;
    logic [IW-1:0] i_reg;
    logic [7:0]    sum_reg;
    logic [7:0]    dlen_reg;
    logic          m_valid_reg;
    logic          found_reg;
    logic [7:0]    start_reg;
    logic [7:0]    length_reg;

    logic          in_xfer;
    logic          out_free;
    logic          commit;
    logic [XW-1:0] s_wide;
    logic [XW-1:0] fill_wide;
    logic [XW-1:0] addr_wide;
    logic [IW:0]   idx_inc;
    logic [IW:0]   sum_end;
    logic [7:0]    want;
    logic [8:0]    len_total;

    assign s_ready  = ctrl.in_rdy;
    assign in_xfer  = s_valid && ctrl.in_rdy;
    assign out_free = !m_valid_reg || m_ready;
    assign commit   = ctrl.commit && out_free;

    assign s_wide    = XW'(s_reg);
    assign fill_wide = XW'(fill_reg);
    assign idx_inc   = {1'b0, i_reg} + (IW+1)'(1);
    assign sum_end   = (IW+1)'(dlen_reg) + (IW+1)'(10);
    assign want      = slave_address_reg[{ctrl.abyte, 3'b000} +: 8];
    assign len_total = {1'b0, dlen_reg} + {1'b0, mfsv_pkg::FrameFixed};

    // Buffer write on every transfer while there is room
    assign wr_en   = in_xfer && (fill_reg < CW'(BUFFER_DEPTH));
    assign wr_addr = fill_reg[AW-1:0];

    // Read address for the byte tested in the next step
    always_comb begin
        case (ctrl.addr_sel)
            mfsv_pkg::ADDR_IDX: addr_wide = s_wide + XW'(idx_inc);
            default:            addr_wide = s_wide + XW'(ctrl.offset);
        endcase
    end
    assign rd_addr = addr_wide[AW-1:0];

    // Condition decoder
    always_comb begin
        unique case (ctrl.test)
            mfsv_pkg::TEST_TRUE:     cond = 1'b1;
            mfsv_pkg::TEST_IN_LAST:  cond = in_xfer && s_last_byte;
            mfsv_pkg::TEST_FITS:
                cond = (s_wide + XW'(mfsv_pkg::FrameFixed)) <= fill_wide;
            mfsv_pkg::TEST_HEAD:     cond = rd_data == mfsv_pkg::FrameHead;
            mfsv_pkg::TEST_CTRL:     cond = rd_data[mfsv_pkg::CtrlDirBit];
            mfsv_pkg::TEST_LEN:
                cond = (rd_data <= 8'(MAX_DATA_LEN))
                    && ((s_wide + XW'(rd_data) + XW'(mfsv_pkg::FrameFixed)) <= fill_wide);
            mfsv_pkg::TEST_MORE:     cond = idx_inc < sum_end;
            mfsv_pkg::TEST_CSUM:     cond = rd_data == sum_reg;
            mfsv_pkg::TEST_TAIL:     cond = rd_data == mfsv_pkg::FrameTail;
            mfsv_pkg::TEST_ADDR:
                cond = (want == 8'h00) || (want == mfsv_pkg::AddrWild) || (rd_data == want);
            mfsv_pkg::TEST_OUT_FREE: cond = out_free;
            default:                 cond = 1'b0;
        endcase
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slave_address_reg <= '0;
        end else if (cfg_wr_en) begin
            slave_address_reg <= cfg_wr_data;
        end
    end

    // Fill count: grows on stored bytes, cleared when the result is issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else if (commit) begin
            fill_reg <= '0;
        end else if (wr_en) begin
            fill_reg <= fill_reg + CW'(1);
        end
    end

    // Scan start
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_reg <= '0;
        end else if (ctrl.s_clr) begin
            s_reg <= '0;
        end else if (ctrl.s_inc) begin
            s_reg <= s_reg + CW'(1);
        end
    end

    // Checksum loop: index, running sum and data length
    always_ff @(posedge aclk) begin
        if (ctrl.acc_clr) begin
            i_reg   <= '0;
            sum_reg <= '0;
        end else if (ctrl.acc_add) begin
            i_reg   <= idx_inc[IW-1:0];
            sum_reg <= sum_reg + rd_data;
        end
        if (ctrl.dlen_ld) begin
            dlen_reg <= rd_data;
        end
    end

    // Result register, free again once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (commit) begin
            found_reg  <= ctrl.hit;
            start_reg  <= ctrl.hit ? s_wide[7:0] : 8'h00;
            length_reg <= ctrl.hit ? len_total[7:0] : 8'h00;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = found_reg;
    assign m_frame_start  = start_reg;
    assign m_frame_length = length_reg;

endmodule

[hw/rtl/meter_frame_search_validate.sv]
// Top level of the meter frame search: buffer, microcode sequencer and datapath.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  input    | s_valid / s_ready       | s_data_byte[7:0], s_last_byte
//  result   | m_valid / m_ready       | m_found, m_frame_start[7:0], m_frame_length[7:0]
//  config   | cfg_wr_en (no wait)     | cfg_wr_data[47:0] = slave_address
//
//  Bytes load one per cycle while the sequencer idles; a transfer with s_last_byte
//  starts the scan. A candidate start that fails the first head check passes through
//  ST_CAND, ST_HEAD0 and ST_NEXT only; one that passes runs through every check; the scan
//  is one byte-buffer read per cycle on a single read port.
//  The result sits in an output register; input stalls only during the scan and
//  while an earlier result still blocks the new one. Reset (aresetn, synchronous,
//  active low) clears the fill count, the sequencer and the address register.
module meter_frame_search_validate #(
    parameter int BUFFER_DEPTH = mfsv_pkg::BufferDepthDef,
    parameter int MAX_DATA_LEN = mfsv_pkg::MaxDataLenDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_found,
    output logic [7:0]  m_frame_start,
    output logic [7:0]  m_frame_length,
    input  logic        cfg_wr_en,
    input  logic [47:0] cfg_wr_data
);

    localparam int AW = $clog2(BUFFER_DEPTH);

    mfsv_pkg::ctrl_t ctrl;
    logic            cond;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr;
    logic [7:0]      rd_data;

    // Program sequencer
    mfsv_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cond    (cond),
        .ctrl    (ctrl)
    );

    // Byte buffer
    mfsv_store #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_data_byte),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Datapath and result register
    mfsv_datapath #(
        .BUFFER_DEPTH (BUFFER_DEPTH),
        .MAX_DATA_LEN (MAX_DATA_LEN)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .cond           (cond),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_found        (m_found),
        .m_frame_start  (m_frame_start),
        .m_frame_length (m_frame_length),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data)
    );

endmodule
